// ----- rtl/dcf_pkg.sv -----
// Shared constants and types for the divisor count factoriser.
package dcf_pkg;

	// Field widths of the input and result transactions
	localparam int IN_W    = 32;
	localparam int PRIME_W = 32;
	localparam int EXP_W   = 5;
	localparam int TOTAL_W = 11;

	// Default number of value bits taken into account
	localparam int VALUE_BITS_DEF = 32;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_TEST,
		ST_DIVIDE,
		ST_CHECK,
		ST_COUNT,
		ST_EMIT
	} dcf_state_t;

endpackage

// ----- rtl/divisor_count_factorizer.sv -----
// Trial division factoriser with divisor count, built round one bit-serial divider.
// Flow (VW = VALUE_BITS capped at 32): a candidate passes square, test, VW divide steps and
// check; a repeat division by a found prime passes the divide steps and check again; a found
// prime adds count and emit plus any wait for the output register; zero goes straight to emit.
// Throughput: one transaction at a time; in_ready only in idle, next value taken while the
// final result waits in the output register. Reset: async active low, idle, nothing pending.
module divisor_count_factorizer #(
	parameter int VALUE_BITS = dcf_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dcf_pkg::IN_W-1:0]      value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dcf_pkg::PRIME_W-1:0]   prime_factor,
	output logic [dcf_pkg::EXP_W-1:0]     exponent,
	output logic [dcf_pkg::TOTAL_W-1:0]   divisor_total,
	output logic                          last,
	output logic                          bad_input
);

	// Bits of value in use, divisor width (room for sqrt plus a step), square width
	localparam int VW  = (VALUE_BITS < dcf_pkg::IN_W) ? VALUE_BITS : dcf_pkg::IN_W;
	localparam int DW  = (VW + 1) / 2 + 2;
	localparam int SW  = 2 * DW;
	localparam int BCW = $clog2(VW);
	localparam int EW  = dcf_pkg::EXP_W;
	localparam int TW  = dcf_pkg::TOTAL_W;
	localparam int PW  = dcf_pkg::PRIME_W;

	dcf_pkg::dcf_state_t state_q, state_d;

	logic [VW-1:0]  rem_q;
	logic [DW-1:0]  div_q;
	logic [EW-1:0]  mult_q;
	logic [TW-1:0]  cnt_q;
	logic [SW-1:0]  sq_q;

	// Bit-serial divider: dividend shifts out at the top, quotient shifts in at the bottom
	logic [VW-1:0]  quo_q;
	logic [DW-1:0]  part_q;
	logic [BCW-1:0] bit_cnt_q;
	logic [DW:0]    trial;
	logic           trial_ge;

	// Pending result, waiting for the output register
	logic [PW-1:0]  pend_prime_q;
	logic [EW-1:0]  pend_exp_q;
	logic [TW-1:0]  pend_total_q;
	logic           pend_last_q;
	logic           pend_bad_q;

	logic [VW-1:0]  value_m;
	logic           value_zero;
	logic           sq_past;
	logic           div_done;
	logic           divisible;
	logic [EW:0]    mult_inc;
	logic [TW+EW:0] cnt_prod;
	logic [DW-1:0]  div_next;
	logic           slot_free;
	logic           emit_fire;

	assign value_m    = value[VW-1:0];
	assign value_zero = (value_m == '0);
	assign sq_past    = (sq_q > SW'(rem_q));
	assign div_done   = (bit_cnt_q == BCW'(VW - 1));
	assign divisible  = (part_q == '0);
	assign trial      = {part_q, quo_q[VW-1]};
	assign trial_ge   = (trial >= {1'b0, div_q});
	assign mult_inc   = {1'b0, mult_q} + (EW+1)'(1);
	assign cnt_prod   = (TW+EW+1)'(cnt_q) * (TW+EW+1)'(mult_inc);
	assign div_next   = (div_q == DW'(2)) ? DW'(3) : div_q + DW'(2);
	assign slot_free  = !out_valid || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dcf_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = value_zero ? dcf_pkg::ST_EMIT : dcf_pkg::ST_SQUARE;
				end
			end
			dcf_pkg::ST_SQUARE: state_d = dcf_pkg::ST_TEST;
			dcf_pkg::ST_TEST: begin
				state_d = sq_past ? dcf_pkg::ST_EMIT : dcf_pkg::ST_DIVIDE;
			end
			dcf_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = dcf_pkg::ST_CHECK;
				end
			end
			dcf_pkg::ST_CHECK: begin
				if (divisible) begin
					state_d = dcf_pkg::ST_DIVIDE;
				end else if (mult_q != '0) begin
					state_d = dcf_pkg::ST_COUNT;
				end else begin
					state_d = dcf_pkg::ST_SQUARE;
				end
			end
			dcf_pkg::ST_COUNT: state_d = dcf_pkg::ST_EMIT;
			dcf_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = pend_last_q ? dcf_pkg::ST_IDLE : dcf_pkg::ST_SQUARE;
				end
			end
			default: state_d = dcf_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		emit_fire = 1'b0;
		case (state_q)
			dcf_pkg::ST_IDLE: in_ready  = 1'b1;
			dcf_pkg::ST_EMIT: emit_fire = slot_free;
			default: begin
				in_ready  = 1'b0;
				emit_fire = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dcf_pkg::ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			dcf_pkg::ST_IDLE: begin
				if (in_valid) begin
					rem_q        <= value_m;
					div_q        <= DW'(2);
					mult_q       <= '0;
					cnt_q        <= TW'(1);
					pend_prime_q <= '0;
					pend_exp_q   <= '0;
					pend_total_q <= '0;
					pend_last_q  <= 1'b1;
					pend_bad_q   <= 1'b1;
				end
			end
			dcf_pkg::ST_SQUARE: begin
				sq_q <= SW'(div_q) * SW'(div_q);
			end
			dcf_pkg::ST_TEST: begin
				if (sq_past) begin
					// Search over: leftover above one is a last prime
					pend_last_q <= 1'b1;
					pend_bad_q  <= 1'b0;
					if (rem_q > VW'(1)) begin
						pend_prime_q <= PW'(rem_q);
						pend_exp_q   <= EW'(1);
						pend_total_q <= {cnt_q[TW-2:0], 1'b0};
						cnt_q        <= {cnt_q[TW-2:0], 1'b0};
						mult_q       <= EW'(1);
					end else begin
						pend_prime_q <= '0;
						pend_exp_q   <= '0;
						pend_total_q <= cnt_q;
					end
				end else begin
					mult_q    <= '0;
					quo_q     <= rem_q;
					part_q    <= '0;
					bit_cnt_q <= '0;
				end
			end
			dcf_pkg::ST_DIVIDE: begin
				part_q    <= trial_ge ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
				quo_q     <= {quo_q[VW-2:0], trial_ge};
				bit_cnt_q <= bit_cnt_q + BCW'(1);
			end
			dcf_pkg::ST_CHECK: begin
				if (divisible) begin
					// Exact: keep the quotient and divide again
					rem_q     <= quo_q;
					mult_q    <= mult_q + EW'(1);
					part_q    <= '0;
					bit_cnt_q <= '0;
				end else if (mult_q == '0) begin
					div_q <= div_next;
				end
			end
			dcf_pkg::ST_COUNT: begin
				cnt_q        <= cnt_prod[TW-1:0];
				pend_prime_q <= PW'(div_q);
				pend_exp_q   <= mult_q;
				pend_bad_q   <= 1'b0;
				if (rem_q == VW'(1)) begin
					pend_total_q <= cnt_prod[TW-1:0];
					pend_last_q  <= 1'b1;
				end else begin
					pend_total_q <= '0;
					pend_last_q  <= 1'b0;
				end
			end
			dcf_pkg::ST_EMIT: begin
				if (slot_free && !pend_last_q) begin
					div_q <= div_next;
				end
			end
			default: begin
				sq_q <= sq_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			prime_factor  <= pend_prime_q;
			exponent      <= pend_exp_q;
			divisor_total <= pend_total_q;
			last          <= pend_last_q;
			bad_input     <= pend_bad_q;
		end
	end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the trial division factoriser, with its own prime and count model.
module tb_top;

	localparam int IN_W         = dcf_pkg::IN_W;
	localparam int PRIME_W      = dcf_pkg::PRIME_W;
	localparam int EXP_W        = dcf_pkg::EXP_W;
	localparam int TOTAL_W      = dcf_pkg::TOTAL_W;
	localparam int VALUE_BITS   = dcf_pkg::VALUE_BITS_DEF;
	localparam int MAX_FACTORS  = 10;
	localparam int STALL_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [PRIME_W-1:0] prime_factor;
		logic [EXP_W-1:0]   exponent;
		logic [TOTAL_W-1:0] divisor_total;
		logic               last;
		logic               bad_input;
	} factor_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [IN_W-1:0]    value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PRIME_W-1:0] prime_factor;
	logic [EXP_W-1:0]   exponent;
	logic [TOTAL_W-1:0] divisor_total;
	logic               last;
	logic               bad_input;

	// Model state: mirrors the search registers of the block
	longint unsigned rem_left;
	longint unsigned trial_div;
	longint unsigned div_count;
	int unsigned     mult;

	factor_result_t expected_factors [$];

	int unsigned small_primes [15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_len = 0;
	int hold_id = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	divisor_count_factorizer #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.prime_factor(prime_factor),
		.exponent(exponent),
		.divisor_total(divisor_total),
		.last(last),
		.bad_input(bad_input)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Queue one expected result, truncated to the port widths
	function automatic void push_factor(input longint unsigned p, input int unsigned e,
			input longint unsigned tot, input logic lst, input logic bad);
		factor_result_t r;
		r.prime_factor  = p[PRIME_W-1:0];
		r.exponent      = e[EXP_W-1:0];
		r.divisor_total = tot[TOTAL_W-1:0];
		r.last          = lst;
		r.bad_input     = bad;
		expected_factors.insert(expected_factors.size(), r);
	endfunction

	// Trial division over 2 then odd candidates; one result per distinct prime, or one for 0 and 1
	function automatic void predict_factors(input logic [IN_W-1:0] v);
		longint unsigned mask;
		int unsigned     emitted;
		mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
		rem_left = longint'(v) & mask;
		emitted = 0;
		if (rem_left == 0) begin
			trial_div = 0;
			mult = 0;
			div_count = 0;
			push_factor(0, 0, 0, 1'b1, 1'b1);
			return;
		end
		div_count = 1;
		mult = 0;
		trial_div = 2;
		while (trial_div * trial_div <= rem_left) begin
			if (rem_left % trial_div == 0) begin
				mult = 0;
				while (rem_left % trial_div == 0) begin
					rem_left = rem_left / trial_div;
					mult++;
				end
				div_count = div_count * (mult + 1);
				if (rem_left == 1) begin
					push_factor(trial_div, mult, div_count, 1'b1, 1'b0);
					return;
				end
				// results past the limit are dropped, the last one never is
				if (emitted < MAX_FACTORS - 1) begin
					push_factor(trial_div, mult, 0, 1'b0, 1'b0);
					emitted++;
				end
			end
			trial_div = (trial_div == 2) ? 3 : trial_div + 2;
		end
		if (rem_left > 1) begin
			mult = 1;
			div_count = div_count * 2;
			push_factor(rem_left, 1, div_count, 1'b1, 1'b0);
		end else begin
			// unit input: no prime at all
			push_factor(0, 0, div_count, 1'b1, 1'b0);
		end
	endfunction

	// Mostly smooth values so the search stays short; some wide and some plain ones
	function automatic logic [IN_W-1:0] random_value();
		int unsigned     pick;
		longint unsigned product;
		longint unsigned factor;
		pick = $urandom_range(99);
		if (pick < 4)
			return IN_W'($urandom_range(1));
		if (pick < 14)
			return IN_W'($urandom_range(65535)) << 16;
		if (pick < 24)
			return IN_W'($urandom_range(1 << 20, 1));
		product = 1;
		repeat ($urandom_range(20, 1)) begin
			factor = small_primes[$urandom_range($urandom_range(14))];
			if (product * factor <= 64'hFFFF_FFFF)
				product = product * factor;
		end
		factor = $urandom_range(65535, 1);
		if (product * factor <= 64'hFFFF_FFFF)
			product = product * factor;
		return IN_W'(product);
	endfunction

	// Offer one transaction; called and returning just after a falling edge
	task automatic send_value(input logic [IN_W-1:0] v);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		predict_factors(v);
		do @(posedge clk); while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic test_special_values();
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'd2);
		send_value(32'd3);
		send_value(32'd4);
	endtask

	task automatic test_field_extremes();
		send_value(32'h8000_0000);  // largest exponent
		send_value(32'hFFFF_FFFF);  // all ones
		send_value(32'd3491888400); // most divisors in 32 bits
		send_value(32'd223092870);  // nine distinct primes
		send_value(32'd63001);      // square of a prime
		send_value(32'd65521);      // prime left over after the search
		send_value(32'hFFF1_0000);  // large leftover prime beside a power of two
		send_value(32'h5555_5555);
		send_value(32'hAAAA_AAAA);
		send_value(32'd30030);
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_value(random_value());
	endtask

	// Receiver holds off while cheap values keep coming, so the input stalls
	task automatic test_output_backpressure();
		in_valid <= 1'b0;
		@(posedge clk);
		hold_len = HOLD_CYCLES;
		hold_id++;
		@(negedge clk);
		for (int k = 0; k < 12; k++)
			send_value(IN_W'(1) << (k * 3 % 32));
	endtask

	// Receiver: random ready, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (hold_id != hold_seen) begin
			hold_seen = hold_id;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		factor_result_t got;
		factor_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = {prime_factor, exponent, divisor_total, last, bad_input};
			if (expected_factors.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result prime %0d exp %0d total %0d last %b bad %b",
					$time, got.prime_factor, got.exponent, got.divisor_total, got.last,
					got.bad_input);
			end else begin
				want = expected_factors.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: expected prime %0d exp %0d total %0d last %b bad %b",
						$time, want.prime_factor, want.exponent, want.divisor_total,
						want.last, want.bad_input);
					$display("%0t: actual   prime %0d exp %0d total %0d last %b bad %b",
						$time, got.prime_factor, got.exponent, got.divisor_total,
						got.last, got.bad_input);
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_gap_pct = 35;
		recv_gap_pct = 77;
		test_special_values();
		test_field_extremes();
		test_random_traffic(38);

		send_gap_pct = 77;
		recv_gap_pct = 35;
		test_random_traffic(38);

		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_random_traffic(37);
		test_output_backpressure();
		in_valid <= 1'b0;

		// drain, then give the block time to show any stray result
		while (expected_factors.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_factors.size() != 0)
			mismatch_count++;

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
